// ===== rtl/mf3_pkg.sv =====
// Shared constants, types and register codes of the 3x3 median filter.
package mf3_pkg;

   // Frame geometry and pixel format.
   localparam int MAX_WIDTH  = 2048;
   localparam int PIXEL_BITS = 16;
   localparam int ADDR_BITS  = $clog2(MAX_WIDTH);
   localparam int WBITS      = ADDR_BITS + 1;
   localparam int CFG_BITS   = 12;
   localparam int ROW_BITS   = CFG_BITS + 1;
   localparam int WIN_SIZE   = 9;
   localparam int WIN_MID    = 4;
   localparam int SAMPLE_BITS = 16;
   localparam int MEDIAN_BITS = 16;

   // Queue between the front and the back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = QPTR_BITS + 1;

   // Configuration register indexes.
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT = 2'd1;

   typedef logic [PIXEL_BITS-1:0] pixel_type;
   typedef pixel_type [WIN_SIZE-1:0] win_type;

   // Request and response payloads.
   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample;
      logic                   drain;
   } req_type;

   typedef struct packed {
      logic [MEDIAN_BITS-1:0] median;
      logic                   frame_end;
   } rsp_type;

   // Which window borders fall outside the frame.
   typedef struct packed {
      logic top_out;
      logic bottom_out;
      logic left_out;
      logic right_out;
   } border_type;

   // One classified pixel position handed from the front to the back.
   typedef struct packed {
      pixel_type  top;
      pixel_type  mid;
      pixel_type  pix;
      logic       primed;
      border_type border;
      logic       frame_end;
   } job_type;

endpackage

// ===== rtl/median_filter_3x3.sv =====
// Top level of the streaming 3x3 median filter.
// The block takes one request per clock while req_ready is high, either a pixel
// in raster order or a drain request, and returns the median of each pixel's 3x3
// neighborhood, with positions outside the frame read as zero. A request passes
// the line store stage, the queue, the window register, stages m1 and m2 and the
// response register; the two line stores are on-chip memories with one registered
// read per request, and the median network is three register stages deep. The
// first image_width + 1 requests of a frame give no response; after the last pixel,
// image_width + 1 drain requests push out the rest, and the last response carries
// frame_end. Drain requests sent before the last pixel are dropped. A register
// write restarts the frame and must only be made while the block is idle. The line
// stores need no clearing pass after reset, and a four-entry queue between intake
// and the median pipeline keeps requests flowing while a response waits.
module median_filter_3x3
   import mf3_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_type                   rsp_data,
   input  logic                      csr_write,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]       csr_wdata
);

   logic                 push_valid;
   job_type              push_data;
   logic                 pop;
   logic                 head_valid;
   job_type              head_data;
   logic [QCNT_BITS-1:0] q_count;

   // Intake, counters and line stores.
   mf3_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .q_count    (q_count),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   // Job queue.
   mf3_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data),
      .count      (q_count)
   );

   // Window and median pipeline.
   mf3_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

// ===== rtl/mf3_front.sv =====
// Front end: request intake, position counters, line stores and job issue.
module mf3_front
   import mf3_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_type                   req_data,
   input  logic                      csr_write,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]       csr_wdata,
   input  logic [QCNT_BITS-1:0]      q_count,
   output logic                      push_valid,
   output job_type                   push_data
);

   // Configuration registers.
   logic [CFG_BITS-1:0]  width_ff, height_ff;
   // Position counters.
   logic [ROW_BITS-1:0]  in_row_ff, in_row_in;
   logic [ADDR_BITS-1:0] in_col_ff, in_col_in;
   logic [CFG_BITS-1:0]  out_row_ff, out_row_in;
   logic [ADDR_BITS-1:0] out_col_ff, out_col_in;
   // Line store stage.
   logic                 b_valid_ff;
   logic [ADDR_BITS-1:0] b_addr_ff;
   pixel_type            b_pix_ff;
   logic                 b_primed_ff;
   border_type           b_border_ff;
   logic                 b_last_ff;
   pixel_type            rd_top_ff, rd_mid_ff;
   logic                 fwd_ff;
   pixel_type            fwd_top_ff, fwd_mid_ff;
   pixel_type            b_top, b_mid;

   pixel_type            top_mem [MAX_WIDTH];
   pixel_type            mid_mem [MAX_WIDTH];

   logic [WBITS-1:0]     w_eff;
   logic [CFG_BITS-1:0]  h_eff;
   logic                 accept, all_in, drop, take;
   logic                 col_last, primed, last;
   pixel_type            pix;
   border_type           border;
   logic [QCNT_BITS:0]   in_flight;

   // Room for the request in the line store stage plus one more in the queue.
   always_comb begin
      in_flight = {1'b0, q_count} + {{QCNT_BITS{1'b0}}, b_valid_ff};
      req_ready = in_flight < (QCNT_BITS+1)'(QUEUE_DEPTH);
   end

   assign accept = req_valid && req_ready;

   // Effective frame size and classification of the request.
   always_comb begin
      if (width_ff == '0) begin
         w_eff = WBITS'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         w_eff = WBITS'(MAX_WIDTH);
      end else begin
         w_eff = WBITS'(width_ff);
      end
      h_eff  = (height_ff == '0) ? CFG_BITS'(1) : height_ff;
      all_in = in_row_ff >= {1'b0, h_eff};
      drop   = req_data.drain && !all_in;
      take   = accept && !drop;
      pix    = all_in ? '0 : req_data.sample[PIXEL_BITS-1:0];
      col_last = ({1'b0, in_col_ff} + WBITS'(1)) >= w_eff;
      primed = (in_row_ff >= ROW_BITS'(2)) ||
               ((in_row_ff == ROW_BITS'(1)) && (in_col_ff != '0));
      border.top_out    = (out_row_ff == '0);
      border.bottom_out = ({1'b0, out_row_ff} + (CFG_BITS+1)'(1)) >= {1'b0, h_eff};
      border.left_out   = (out_col_ff == '0);
      border.right_out  = ({1'b0, out_col_ff} + WBITS'(1)) >= w_eff;
      last = primed && border.bottom_out && border.right_out;
   end

   // Next counter values for a taken request.
   always_comb begin
      in_col_in  = col_last ? '0 : in_col_ff + ADDR_BITS'(1);
      in_row_in  = col_last ? in_row_ff + ROW_BITS'(1) : in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (primed) begin
         if (border.right_out) begin
            out_col_in = '0;
            out_row_in = out_row_ff + CFG_BITS'(1);
         end else begin
            out_col_in = out_col_ff + ADDR_BITS'(1);
         end
      end
      if (last) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end
   end

   // Configuration registers and counters; a register write restarts the frame.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= CFG_BITS'(640);
         height_ff  <= CFG_BITS'(480);
         in_row_ff  <= '0;
         in_col_ff  <= '0;
         out_row_ff <= '0;
         out_col_ff <= '0;
         b_valid_ff <= 1'b0;
         fwd_ff     <= 1'b0;
      end else begin
         b_valid_ff <= take;
         if (accept) begin
            fwd_ff <= b_valid_ff && (b_addr_ff == in_col_ff);
         end
         if (csr_write) begin
            if (csr_index == CSR_IMAGE_WIDTH) begin
               width_ff <= csr_wdata;
            end
            if (csr_index == CSR_IMAGE_WIDTH || csr_index == CSR_IMAGE_HEIGHT) begin
               in_row_ff  <= '0;
               in_col_ff  <= '0;
               out_row_ff <= '0;
               out_col_ff <= '0;
            end
            if (csr_index == CSR_IMAGE_HEIGHT) begin
               height_ff <= csr_wdata;
            end
         end else if (take) begin
            in_row_ff  <= in_row_in;
            in_col_ff  <= in_col_in;
            out_row_ff <= out_row_in;
            out_col_ff <= out_col_in;
         end
      end
   end

   // Payload of the line store stage.
   always_ff @(posedge clock) begin
      if (accept) begin
         b_addr_ff   <= in_col_ff;
         b_pix_ff    <= pix;
         b_primed_ff <= primed;
         b_border_ff <= border;
         b_last_ff   <= last;
         fwd_top_ff  <= b_mid;
         fwd_mid_ff  <= b_pix_ff;
      end
   end

   // A one-pixel-wide frame reads the column that the previous request writes
   // in the same cycle; those values are taken from the stage registers.
   always_comb begin
      b_top = fwd_ff ? fwd_top_ff : rd_top_ff;
      b_mid = fwd_ff ? fwd_mid_ff : rd_mid_ff;
   end

   // Line store of the upper row.
   always_ff @(posedge clock) begin
      if (b_valid_ff) begin
         top_mem[b_addr_ff] <= b_mid;
      end
      if (accept) begin
         rd_top_ff <= top_mem[in_col_ff];
      end
   end

   // Line store of the middle row.
   always_ff @(posedge clock) begin
      if (b_valid_ff) begin
         mid_mem[b_addr_ff] <= b_pix_ff;
      end
      if (accept) begin
         rd_mid_ff <= mid_mem[in_col_ff];
      end
   end

   // Job handed to the queue.
   always_comb begin
      push_valid          = b_valid_ff;
      push_data.top       = b_top;
      push_data.mid       = b_mid;
      push_data.pix       = b_pix_ff;
      push_data.primed    = b_primed_ff;
      push_data.border    = b_border_ff;
      push_data.frame_end = b_last_ff;
   end

endmodule

// ===== rtl/mf3_queue.sv =====
// Short job queue between the front end and the median back end.
module mf3_queue
   import mf3_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  job_type              push_data,
   input  logic                 pop,
   output logic                 head_valid,
   output job_type              head_data,
   output logic [QCNT_BITS-1:0] count
);

   job_type                slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_BITS-1:0]   count_ff;
   logic                   do_pop;

   assign do_pop     = pop && (count_ff != '0);
   assign head_valid = (count_ff != '0);
   assign head_data  = slot_ff[rd_ptr_ff];
   assign count      = count_ff;

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_valid) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_BITS'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_BITS'(1);
         end
         if (push_valid && !do_pop) begin
            count_ff <= count_ff + QCNT_BITS'(1);
         end else if (do_pop && !push_valid) begin
            count_ff <= count_ff - QCNT_BITS'(1);
         end
      end
   end

   // Slot storage.
   always_ff @(posedge clock) begin
      if (push_valid) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/mf3_back.sv =====
// Back end: 3x3 window, pipelined median network and response register.
module mf3_back
   import mf3_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    head_valid,
   input  job_type head_data,
   output logic    pop,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   win_type    window_ff;
   logic       win_show_ff;
   border_type win_border_ff;
   logic       win_last_ff;
   win_type    m1_ff, m2_ff;
   logic       m1_valid_ff, m2_valid_ff;
   logic       m1_last_ff, m2_last_ff;
   logic       rsp_valid_ff;
   rsp_type    rsp_ff;
   logic       advance;
   win_type    masked, m1_next, m2_next;
   pixel_type  med;

   // Compare and exchange: the smaller value goes to position a.
   function automatic win_type cx(input win_type v, input int a, input int b);
      win_type   r;
      pixel_type t;
      r = v;
      if (r[a] > r[b]) begin
         t    = r[a];
         r[a] = r[b];
         r[b] = t;
      end
      return r;
   endfunction

   // First layer: sort each row of three.
   function automatic win_type sort_rows(input win_type v);
      win_type r;
      r = cx(v, 1, 2);
      r = cx(r, 4, 5);
      r = cx(r, 7, 8);
      r = cx(r, 0, 1);
      r = cx(r, 3, 4);
      r = cx(r, 6, 7);
      r = cx(r, 1, 2);
      r = cx(r, 4, 5);
      r = cx(r, 7, 8);
      return r;
   endfunction

   // Second layer: column maxima, medians and minima narrowed down.
   function automatic win_type sort_cols(input win_type v);
      win_type r;
      r = cx(v, 0, 3);
      r = cx(r, 5, 8);
      r = cx(r, 4, 7);
      r = cx(r, 3, 6);
      r = cx(r, 1, 4);
      r = cx(r, 2, 5);
      r = cx(r, 4, 7);
      return r;
   endfunction

   // Last layer: median of the three remaining candidates.
   function automatic pixel_type pick_mid(input win_type v);
      win_type r;
      r = cx(v, 4, 2);
      r = cx(r, 6, 4);
      r = cx(r, 4, 2);
      return r[WIN_MID];
   endfunction

   // The whole back end moves when the response register is free.
   assign advance = !rsp_valid_ff || rsp_ready;
   assign pop     = advance && head_valid;

   // Zero the window positions that fall outside the frame.
   always_comb begin
      for (int i = 0; i < WIN_SIZE; i++) begin
         if ((i < 3 && win_border_ff.top_out) || (i >= 6 && win_border_ff.bottom_out) ||
             ((i % 3) == 0 && win_border_ff.left_out) ||
             ((i % 3) == 2 && win_border_ff.right_out)) begin
            masked[i] = '0;
         end else begin
            masked[i] = window_ff[i];
         end
      end
      m1_next = sort_rows(masked);
      m2_next = sort_cols(m1_ff);
      med     = pick_mid(m2_ff);
   end

   // Window shift and stage valids.
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= '0;
         win_show_ff  <= 1'b0;
         m1_valid_ff  <= 1'b0;
         m2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         win_show_ff  <= pop && head_data.primed;
         m1_valid_ff  <= win_show_ff;
         m2_valid_ff  <= m1_valid_ff;
         rsp_valid_ff <= m2_valid_ff;
         if (pop) begin
            for (int r = 0; r < 3; r++) begin
               window_ff[3*r]     <= window_ff[3*r + 1];
               window_ff[3*r + 1] <= window_ff[3*r + 2];
            end
            window_ff[2] <= head_data.top;
            window_ff[5] <= head_data.mid;
            window_ff[8] <= head_data.pix;
         end
      end
   end

   // Pipeline payload.
   always_ff @(posedge clock) begin
      if (advance) begin
         if (pop) begin
            win_border_ff <= head_data.border;
            win_last_ff   <= head_data.frame_end;
         end
         m1_ff                <= m1_next;
         m1_last_ff           <= win_last_ff;
         m2_ff                <= m2_next;
         m2_last_ff           <= m1_last_ff;
         rsp_ff.median        <= MEDIAN_BITS'(med);
         rsp_ff.frame_end     <= m2_last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
